/* rtl/sct_pkg.sv */
// Shared types and constants for the symmetrical component transform core.
package sct_pkg;

    localparam int COMP_W      = 32;
    localparam int DUST_W      = 31;
    localparam int NUM_STAGES  = 8;
    localparam int LANE_STAGES = 7;

    // sqrt(3)/2 as an unsigned Q0.32 value.
    localparam logic [31:0] ROOT3ON2_Q32 = 32'd3719550787;
    localparam logic [63:0] ROUND_HALF   = 64'h0000_0000_4000_0000;

    // ceil(2^34 / 3): exact reciprocal for dividends below 2^33.
    localparam logic [33:0] DIV3_MAGIC = 34'd5726623062;
    localparam int          DIV3_SHIFT = 34;

    localparam logic [34:0] SAT_LIMIT  = 35'd2147483648;
    localparam logic [34:0] DIV3_LIMIT = 35'd6442450944;

    typedef enum logic [1:0] {
        LANE_X = 2'd0,
        LANE_Y = 2'd1,
        LANE_Z = 2'd2
    } lane_kind_t;

    typedef enum logic [1:0] {
        DIV1 = 2'd0,
        DIV2 = 2'd1,
        DIV3 = 2'd2,
        DIV6 = 2'd3
    } div_sel_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SUBST  = 2'd1,
        ST_DOMAIN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_COMPLEX_ENABLE  = 2'd0,
        CFG_SPECIAL_RESULTS = 2'd1,
        CFG_DUST_LIMIT      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

endpackage

/* rtl/symmetrical_component_transform_core.sv */
// Throughput: one beat per cycle while m_ready accepts results; the eight pipeline stages
// each hold a beat and close bubbles independently, so input is still taken while a
// finished result waits at the output, as long as an earlier stage is empty.
// Reset (aresetn low at a clock edge) empties the pipeline, clears the complex latch
// and sets all three configuration registers to zero.
module symmetrical_component_transform_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [31:0] s_x_re,
    input  logic signed [31:0] s_x_im,
    input  logic signed [31:0] s_y_re,
    input  logic signed [31:0] s_y_im,
    input  logic signed [31:0] s_z_re,
    input  logic signed [31:0] s_z_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x_re,
    output logic signed [31:0] m_out_x_im,
    output logic signed [31:0] m_out_y_re,
    output logic signed [31:0] m_out_y_im,
    output logic signed [31:0] m_out_z_re,
    output logic signed [31:0] m_out_z_im,
    output logic [1:0]         m_status
);
    import sct_pkg::*;

    pipe_ctl_t               ctl;
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES-1:0]   vld_next;
    logic [LANE_STAGES-1:0]  allow_reg;
    logic                    s_accept;
    logic                    in_complex;
    logic                    complex_latch_reg;
    logic                    complex_enable_reg;
    logic                    special_results_reg;
    logic [30:0]             dust_limit_reg;

    logic signed [31:0]      lx_re, lx_im, ly_re, ly_im, lz_re, lz_im;

    // A stage may load when it is empty or its beat moves on in the same cycle.
    always_comb begin
        ctl.en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !vld_reg[k] || ctl.en[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (ctl.en[k]) begin
                vld_next[k] = (k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    assign s_ready    = ctl.en[0];
    assign s_accept   = s_valid && s_ready;
    assign in_complex = (s_x_im != 32'sd0) || (s_y_im != 32'sd0) || (s_z_im != 32'sd0);
    assign m_valid    = vld_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg             <= '0;
            complex_latch_reg   <= 1'b0;
            complex_enable_reg  <= 1'b0;
            special_results_reg <= 1'b0;
            dust_limit_reg      <= '0;
        end else begin
            vld_reg <= vld_next;
            if (s_accept && in_complex) begin
                complex_latch_reg <= 1'b1;
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_COMPLEX_ENABLE:  complex_enable_reg  <= cfg_wdata[0];
                    CFG_SPECIAL_RESULTS: special_results_reg <= cfg_wdata[0];
                    CFG_DUST_LIMIT:      dust_limit_reg      <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // The latch value that a beat sees includes its own inputs.
    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            allow_reg[0] <= complex_latch_reg || in_complex;
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (ctl.en[k]) begin
                allow_reg[k] <= allow_reg[k-1];
            end
        end
    end

    sct_lane u_lane_x (
        .aclk    (aclk),
        .ctl     (ctl),
        .kind    (LANE_X),
        .command (s_command),
        .x_re    (s_x_re),
        .x_im    (s_x_im),
        .y_re    (s_y_re),
        .y_im    (s_y_im),
        .z_re    (s_z_re),
        .z_im    (s_z_im),
        .res_re  (lx_re),
        .res_im  (lx_im)
    );

    sct_lane u_lane_y (
        .aclk    (aclk),
        .ctl     (ctl),
        .kind    (LANE_Y),
        .command (s_command),
        .x_re    (s_x_re),
        .x_im    (s_x_im),
        .y_re    (s_y_re),
        .y_im    (s_y_im),
        .z_re    (s_z_re),
        .z_im    (s_z_im),
        .res_re  (ly_re),
        .res_im  (ly_im)
    );

    sct_lane u_lane_z (
        .aclk    (aclk),
        .ctl     (ctl),
        .kind    (LANE_Z),
        .command (s_command),
        .x_re    (s_x_re),
        .x_im    (s_x_im),
        .y_re    (s_y_re),
        .y_im    (s_y_im),
        .z_re    (s_z_re),
        .z_im    (s_z_im),
        .res_re  (lz_re),
        .res_im  (lz_im)
    );

    sct_merge u_merge (
        .aclk            (aclk),
        .ctl             (ctl),
        .allow           (allow_reg[LANE_STAGES-1]),
        .complex_enable  (complex_enable_reg),
        .special_results (special_results_reg),
        .dust_limit      (dust_limit_reg),
        .x_re            (lx_re),
        .x_im            (lx_im),
        .y_re            (ly_re),
        .y_im            (ly_im),
        .z_re            (lz_re),
        .z_im            (lz_im),
        .out_x_re        (m_out_x_re),
        .out_x_im        (m_out_x_im),
        .out_y_re        (m_out_y_re),
        .out_y_im        (m_out_y_im),
        .out_z_re        (m_out_z_re),
        .out_z_im        (m_out_z_im),
        .status          (m_status)
    );

endmodule

/* rtl/sct_lane.sv */
// One transform lane: computes a single output phasor through a seven stage pipeline.
module sct_lane (
    input  logic                     aclk,
    input  sct_pkg::pipe_ctl_t       ctl,
    input  sct_pkg::lane_kind_t      kind,
    input  logic                     command,
    input  logic signed [31:0]       x_re,
    input  logic signed [31:0]       x_im,
    input  logic signed [31:0]       y_re,
    input  logic signed [31:0]       y_im,
    input  logic signed [31:0]       z_re,
    input  logic signed [31:0]       z_im,
    output logic signed [31:0]       res_re,
    output logic signed [31:0]       res_im
);
    import sct_pkg::*;

    logic signed [34:0] xr35, yr35, zr35, xi35, yi35, zi35;
    logic signed [32:0] d_re, d_im;
    logic               flip;

    logic signed [34:0] a_next [2];
    logic [31:0]        dmag_next [2];
    logic               sub_next [2];
    div_sel_t           div_next;

    logic signed [34:0] a_s0_reg [2];
    logic [31:0]        dmag_s0_reg [2];
    logic               sub_s0_reg [2];
    div_sel_t           div_s0_reg;

    logic [63:0]        prod_next [2];
    logic [63:0]        prod_s1_reg [2];
    logic signed [34:0] a_s1_reg [2];
    logic               sub_s1_reg [2];
    div_sel_t           div_s1_reg;

    logic [63:0]        rsum [2];
    logic [32:0]        r_next [2];
    logic [32:0]        r_s2_reg [2];
    logic signed [34:0] a_s2_reg [2];
    logic               sub_s2_reg [2];
    div_sel_t           div_s2_reg;

    logic signed [34:0] n_next [2];
    logic signed [34:0] n_s3_reg [2];
    div_sel_t           div_s3_reg;

    logic [33:0]        mag_s4 [2];
    logic [34:0]        t_s4 [2];
    logic [34:0]        lim_s4;
    logic               use3_next;
    logic [32:0]        tc_next [2];
    logic [32:0]        tc_s4_reg [2];
    logic               neg_s4_reg [2];
    logic               use3_s4_reg;

    logic [48:0]        pph_next [2];
    logic [49:0]        ppl_next [2];
    logic [48:0]        pph_s5_reg [2];
    logic [49:0]        ppl_s5_reg [2];
    logic [32:0]        tc_s5_reg [2];
    logic               neg_s5_reg [2];
    logic               use3_s5_reg;

    logic [65:0]        full_s6 [2];
    logic [31:0]        q_s6 [2];
    logic signed [31:0] res_next [2];
    logic signed [31:0] res_reg [2];

    assign xr35 = 35'(x_re);
    assign yr35 = 35'(y_re);
    assign zr35 = 35'(z_re);
    assign xi35 = 35'(x_im);
    assign yi35 = 35'(y_im);
    assign zi35 = 35'(z_im);
    assign d_re = 33'(y_im) - 33'(x_im);
    assign d_im = 33'(y_re) - 33'(x_re);

    // The X lane of the forward transform and the Y lane of the inverse share one sign pattern.
    always_comb begin
        flip = (kind == LANE_X) ^ command;
        if (kind == LANE_Z) begin
            a_next[0]    = zr35 + yr35 + xr35;
            a_next[1]    = zi35 + yi35 + xi35;
            dmag_next[0] = '0;
            dmag_next[1] = '0;
            sub_next[0]  = 1'b0;
            sub_next[1]  = 1'b0;
            div_next     = command ? DIV3 : DIV1;
        end else begin
            a_next[0]    = (zr35 <<< 1) - yr35 - xr35;
            a_next[1]    = (zi35 <<< 1) - yi35 - xi35;
            dmag_next[0] = d_re[32] ? 32'(-d_re) : d_re[31:0];
            dmag_next[1] = d_im[32] ? 32'(-d_im) : d_im[31:0];
            sub_next[0]  = flip ^ d_re[32];
            sub_next[1]  = ~flip ^ d_im[32];
            div_next     = command ? DIV6 : DIV2;
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            prod_next[i] = 64'(dmag_s0_reg[i]) * 64'(ROOT3ON2_Q32);
            rsum[i]      = prod_s1_reg[i] + ROUND_HALF;
            r_next[i]    = rsum[i][63:31];
            n_next[i]    = sub_s2_reg[i] ? a_s2_reg[i] - $signed({2'b00, r_s2_reg[i]})
                                         : a_s2_reg[i] + $signed({2'b00, r_s2_reg[i]});
        end
    end

    always_comb begin
        use3_next = (div_s3_reg == DIV3) || (div_s3_reg == DIV6);
        lim_s4    = use3_next ? DIV3_LIMIT : SAT_LIMIT;
        for (int i = 0; i < 2; i++) begin
            mag_s4[i] = n_s3_reg[i][34] ? 34'(-n_s3_reg[i]) : n_s3_reg[i][33:0];
            case (div_s3_reg)
                DIV1: t_s4[i] = 35'(mag_s4[i]);
                DIV2: t_s4[i] = (35'(mag_s4[i]) + 35'd1) >> 1;
                DIV3: t_s4[i] = 35'(mag_s4[i]) + 35'd1;
                DIV6: t_s4[i] = (35'(mag_s4[i]) + 35'd3) >> 1;
                default: t_s4[i] = 35'(mag_s4[i]);
            endcase
            tc_next[i] = (t_s4[i] > lim_s4) ? lim_s4[32:0] : t_s4[i][32:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            pph_next[i] = 49'(tc_s4_reg[i]) * 49'(DIV3_MAGIC[32:17]);
            ppl_next[i] = 50'(tc_s4_reg[i]) * 50'(DIV3_MAGIC[16:0]);
            full_s6[i]  = (66'(pph_s5_reg[i]) << 17) + 66'(ppl_s5_reg[i]);
            q_s6[i]     = use3_s5_reg ? full_s6[i][65:DIV3_SHIFT] : tc_s5_reg[i][31:0];
            if (neg_s5_reg[i]) begin
                res_next[i] = $signed(-q_s6[i]);
            end else if (q_s6[i][31]) begin
                res_next[i] = 32'sh7FFF_FFFF;
            end else begin
                res_next[i] = $signed(q_s6[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            a_s0_reg    <= a_next;
            dmag_s0_reg <= dmag_next;
            sub_s0_reg  <= sub_next;
            div_s0_reg  <= div_next;
        end
        if (ctl.en[1]) begin
            prod_s1_reg <= prod_next;
            a_s1_reg    <= a_s0_reg;
            sub_s1_reg  <= sub_s0_reg;
            div_s1_reg  <= div_s0_reg;
        end
        if (ctl.en[2]) begin
            r_s2_reg   <= r_next;
            a_s2_reg   <= a_s1_reg;
            sub_s2_reg <= sub_s1_reg;
            div_s2_reg <= div_s1_reg;
        end
        if (ctl.en[3]) begin
            n_s3_reg   <= n_next;
            div_s3_reg <= div_s2_reg;
        end
        if (ctl.en[4]) begin
            tc_s4_reg     <= tc_next;
            neg_s4_reg[0] <= n_s3_reg[0][34];
            neg_s4_reg[1] <= n_s3_reg[1][34];
            use3_s4_reg   <= use3_next;
        end
        if (ctl.en[5]) begin
            pph_s5_reg  <= pph_next;
            ppl_s5_reg  <= ppl_next;
            tc_s5_reg   <= tc_s4_reg;
            neg_s5_reg  <= neg_s4_reg;
            use3_s5_reg <= use3_s4_reg;
        end
        if (ctl.en[6]) begin
            res_reg <= res_next;
        end
    end

    assign res_re = res_reg[0];
    assign res_im = res_reg[1];

endmodule

/* rtl/sct_merge.sv */
// Merging stage: gates lane results on dust, the complex setting and latch; holds the output beat.
module sct_merge (
    input  logic                 aclk,
    input  sct_pkg::pipe_ctl_t   ctl,
    input  logic                 allow,
    input  logic                 complex_enable,
    input  logic                 special_results,
    input  logic [30:0]          dust_limit,
    input  logic signed [31:0]   x_re,
    input  logic signed [31:0]   x_im,
    input  logic signed [31:0]   y_re,
    input  logic signed [31:0]   y_im,
    input  logic signed [31:0]   z_re,
    input  logic signed [31:0]   z_im,
    output logic signed [31:0]   out_x_re,
    output logic signed [31:0]   out_x_im,
    output logic signed [31:0]   out_y_re,
    output logic signed [31:0]   out_y_im,
    output logic signed [31:0]   out_z_re,
    output logic signed [31:0]   out_z_im,
    output logic [1:0]           status
);
    import sct_pkg::*;

    function automatic logic is_dust(input logic signed [31:0] v, input logic [30:0] limit);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return (v == 32'sd0) || (m < {1'b0, limit});
    endfunction

    logic               refuse;
    status_t            status_next;
    logic signed [31:0] out_x_re_reg, out_x_im_reg;
    logic signed [31:0] out_y_re_reg, out_y_im_reg;
    logic signed [31:0] out_z_re_reg, out_z_im_reg;
    status_t            status_reg;

    always_comb begin
        refuse = !complex_enable && !allow &&
                 (!is_dust(x_im, dust_limit) || !is_dust(y_im, dust_limit) ||
                  !is_dust(z_im, dust_limit));
        if (!refuse) begin
            status_next = ST_OK;
        end else if (special_results) begin
            status_next = ST_SUBST;
        end else begin
            status_next = ST_DOMAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[NUM_STAGES-1]) begin
            out_x_re_reg <= refuse ? '0 : x_re;
            out_x_im_reg <= refuse ? '0 : x_im;
            out_y_re_reg <= refuse ? '0 : y_re;
            out_y_im_reg <= refuse ? '0 : y_im;
            out_z_re_reg <= refuse ? '0 : z_re;
            out_z_im_reg <= refuse ? '0 : z_im;
            status_reg   <= status_next;
        end
    end

    assign out_x_re = out_x_re_reg;
    assign out_x_im = out_x_im_reg;
    assign out_y_re = out_y_re_reg;
    assign out_y_im = out_y_im_reg;
    assign out_z_re = out_z_re_reg;
    assign out_z_im = out_z_im_reg;
    assign status   = status_reg;

endmodule
